>>> src/abcd_pkg.sv
// ----------------------------------------------------------------------------
// abcd_pkg
// Shared types and constants for the accelerometer burst click detector.
// ----------------------------------------------------------------------------
package abcd_pkg;

	localparam int AXIS_W  = 16;
	localparam int ACT_W   = 18;
	localparam int TOTAL_W = 32;
	localparam int EV_W    = 2;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	typedef logic signed [AXIS_W-1:0]  axis_t;
	typedef logic        [ACT_W-1:0]   act_t;
	typedef logic        [TOTAL_W-1:0] total_t;
	typedef logic        [EV_W-1:0]    ev_t;

	// event_res codes
	localparam ev_t EV_BUSY  = 2'd0;
	localparam ev_t EV_QUIET = 2'd1;
	localparam ev_t EV_CLICK = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_ACT_THR   = 1'b0;
	localparam logic REG_CLICK_THR = 1'b1;

	localparam act_t   ACT_THR_RST   = 18'd1000;
	localparam total_t CLICK_THR_RST = 32'd20000;

endpackage

>>> src/abcd_accel_if.sv
// ----------------------------------------------------------------------------
// abcd_accel_if
// Request channel carrying one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
interface abcd_accel_if import abcd_pkg::*;;
	logic  valid;
	logic  ready;
	axis_t accel_x;
	axis_t accel_y;
	axis_t accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		output ready);
endinterface

>>> src/abcd_event_if.sv
// ----------------------------------------------------------------------------
// abcd_event_if
// Request channel carrying one detector result: event code and activity.
// ----------------------------------------------------------------------------
interface abcd_event_if import abcd_pkg::*;;
	logic valid;
	logic ready;
	ev_t  event_res;
	act_t activity;

	modport source (output valid, output event_res, output activity, input ready);
	modport sink (input valid, input event_res, input activity, output ready);
endinterface

>>> src/accel_burst_click_detector.sv
// ----------------------------------------------------------------------------
// accel_burst_click_detector
// Burst click detector over a stream of three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// One result per sample. A sample is held in an input register, then the
// activity sum, burst bookkeeping and saturating total update run in a
// single pass into the result register, so the block takes a sample every
// cycle unless the output stalls; results leave from the result register.
// The output register stalls back into the input register only when the
// consumer holds ready low. The first sample after reset only primes the
// previous-sample registers and reports event 0. The lead values are kept
// as a running sum, so no lead storage is needed. Registers: 0x0 activity
// threshold (18 bit), 0x4 click threshold (32 bit); both compare strictly.
// ----------------------------------------------------------------------------
module accel_burst_click_detector import abcd_pkg::*; #(
	parameter int LEAD_SAMPLES = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	abcd_accel_if.sink        accel,
	abcd_event_if.source      detect,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W  = $clog2(LEAD_SAMPLES + 1);
	localparam int LSUM_W = ACT_W + CNT_W;
	localparam logic [CNT_W-1:0] LEAD_N = CNT_W'(LEAD_SAMPLES);

	// configuration
	act_t   act_thr_q;
	total_t click_thr_q;
	logic   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_thr_q   <= ACT_THR_RST;
			click_thr_q <= CLICK_THR_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ACT_THR:   act_thr_q   <= pwdata[ACT_W-1:0];
				REG_CLICK_THR: click_thr_q <= pwdata[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ACT_THR:   prdata = {{(DATA_W-ACT_W){1'b0}}, act_thr_q};
			REG_CLICK_THR: prdata = click_thr_q;
			default:       prdata = '0;
		endcase
	end

	// pipeline control
	logic  valid_s1;
	axis_t x_s1, y_s1, z_s1;
	logic  out_valid_q;
	logic  advance;
	logic  step;

	assign advance     = !out_valid_q || detect.ready;
	assign accel.ready = !valid_s1 || advance;
	assign step        = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accel.ready) begin
			valid_s1 <= accel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accel.ready && accel.valid) begin
			x_s1 <= accel.accel_x;
			y_s1 <= accel.accel_y;
			z_s1 <= accel.accel_z;
		end
	end

	// detector state
	axis_t             prev_x_q, prev_y_q, prev_z_q;
	logic              primed_q;
	logic [CNT_W-1:0]  lead_cnt_q;
	logic [LSUM_W-1:0] lead_sum_q;
	logic              burst_q;
	total_t            total_q;

	logic [AXIS_W:0]   dx, dy, dz;
	act_t              act;
	logic              hot;
	logic              burst_n;
	logic [CNT_W-1:0]  lead_cnt_n;
	logic [LSUM_W-1:0] lead_sum_n;
	total_t            total_n;
	ev_t               ev;
	logic [TOTAL_W:0]  add_act, add_lead;
	total_t            sat_act, sat_lead;

	function automatic logic [AXIS_W:0] abs_diff(axis_t a, axis_t b);
		logic signed [AXIS_W:0] d;
		d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
		return d[AXIS_W] ? -d : d;
	endfunction

	always_comb begin
		dx  = abs_diff(x_s1, prev_x_q);
		dy  = abs_diff(y_s1, prev_y_q);
		dz  = abs_diff(z_s1, prev_z_q);
		act = ACT_W'(dx) + ACT_W'(dy) + ACT_W'(dz);
		hot = act > act_thr_q;

		add_act  = {1'b0, total_q} + (TOTAL_W+1)'(act);
		add_lead = {1'b0, total_q} + (TOTAL_W+1)'(lead_sum_q);
		sat_act  = add_act[TOTAL_W]  ? '1 : add_act[TOTAL_W-1:0];
		sat_lead = add_lead[TOTAL_W] ? '1 : add_lead[TOTAL_W-1:0];

		burst_n    = burst_q;
		lead_cnt_n = lead_cnt_q;
		lead_sum_n = lead_sum_q;
		total_n    = total_q;
		ev         = EV_BUSY;

		if (hot) begin
			if (lead_cnt_q >= LEAD_N) begin
				burst_n = 1'b1;
				total_n = sat_act;
			end else begin
				lead_cnt_n = lead_cnt_q + 1'b1;
				// first lead value of a run restarts the sum
				lead_sum_n = (lead_cnt_q == '0) ? LSUM_W'(act)
				                                : lead_sum_q + LSUM_W'(act);
				if (burst_q) total_n = sat_act;
			end
		end else begin
			lead_cnt_n = '0;
			burst_n    = 1'b0;
			total_n    = '0;
			ev         = (burst_q && sat_lead > click_thr_q) ? EV_CLICK : EV_QUIET;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			prev_x_q <= x_s1;
			prev_y_q <= y_s1;
			prev_z_q <= z_s1;
			if (primed_q) lead_sum_q <= lead_sum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q   <= 1'b0;
			lead_cnt_q <= '0;
			burst_q    <= 1'b0;
			total_q    <= '0;
		end else if (step) begin
			primed_q <= 1'b1;
			if (primed_q) begin
				lead_cnt_q <= lead_cnt_n;
				burst_q    <= burst_n;
				total_q    <= total_n;
			end
		end
	end

	// result register
	ev_t  ev_q;
	act_t act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_q  <= primed_q ? ev  : EV_BUSY;
			act_q <= primed_q ? act : '0;
		end
	end

	assign detect.valid     = out_valid_q;
	assign detect.event_res = ev_q;
	assign detect.activity  = act_q;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for accel_burst_click_detector. Samples go in through
// the accel channel and results come back on the detect channel, both with
// random stalls. A short table of hand-picked samples comes first. Random
// phases follow, each under its own pair of thresholds. The run ends with
// one long full-swing burst under a click threshold one below the largest.
// Results are checked against the table or a cycle-free copy of the detector.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import abcd_pkg::*;

	localparam int              LEADS    = 5;
	localparam int              ACT_MAX  = 196605;
	localparam longint unsigned SUM_MAX  = 64'hFFFF_FFFF;
	localparam int              LONG_RUN = 30;
	localparam int              HOLD_LEN = 80;
	localparam axis_t           AX_MAX   = 16'h7fff;
	localparam axis_t           AX_MIN   = 16'h8000;

	typedef struct { axis_t x; axis_t y; axis_t z; } sample_t;
	typedef struct { ev_t ev; act_t act; } detect_t;
	typedef struct { int x; int y; int z; bit typed; ev_t ev; int act; } vec_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	abcd_accel_if accel_ch ();
	abcd_event_if event_ch ();

	accel_burst_click_detector #(.LEAD_SAMPLES(LEADS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.accel   (accel_ch),
		.detect  (event_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// detector copy
	int unsigned     act_thr = 32'(ACT_THR_RST);
	int unsigned     click_thr = CLICK_THR_RST;
	axis_t           last_x;
	axis_t           last_y;
	axis_t           last_z;
	bit              primed = 1'b0;
	int              lead_cnt = 0;
	bit              burst_on = 1'b0;
	longint unsigned burst_sum = 0;
	int              lead_vals [LEADS];

	detect_t         due_detects [$];
	int              gen_pos [3] = '{0, 0, 0};
	int              src_idle = 36;
	int              sink_idle = 36;
	bit              hold_req = 1'b0;
	int              errors = 0;

	// priming, full-scale swings, a click, activity right at and just above
	// threshold, a run of exactly five leads, then a burst too weak to click
	vec_t dir_vecs [] = '{
		'{ 32767, -32768,      0, 1'b1, EV_BUSY,  0},
		'{-32768,  32767,      0, 1'b1, EV_BUSY,  131070},
		'{ 32767, -32768, -32768, 1'b1, EV_BUSY,  163838},
		'{-32768,  32767,  32767, 1'b1, EV_BUSY,  196605},
		'{ 32767, -32768, -32768, 1'b1, EV_BUSY,  196605},
		'{-32768,  32767,  32767, 1'b1, EV_BUSY,  196605},
		'{ 32767, -32768, -32768, 1'b1, EV_BUSY,  196605},
		'{ 32767, -32768, -32768, 1'b1, EV_CLICK, 0},
		'{ 32767, -32768, -32768, 1'b1, EV_QUIET, 0},
		'{ 31767, -32768, -32768, 1'b1, EV_QUIET, 1000},
		'{ 30766, -32768, -32768, 1'b1, EV_BUSY,  1001},
		'{ 29765, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 28764, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 27763, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 26762, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 26762, -32768, -32768, 1'b1, EV_QUIET, 0},
		'{ 25761, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 24760, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 23759, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 22758, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 21757, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 20756, -32768, -32768, 1'b0, EV_BUSY,  0},
		'{ 20756, -32768, -32768, 1'b0, EV_BUSY,  0}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int axis_gap(axis_t a, axis_t b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	function automatic detect_t predict_detect(sample_t s);
		detect_t r;
		int      a;
		int      i;
		r.ev = EV_BUSY;
		r.act = '0;
		if (!primed) begin
			primed = 1'b1;
		end else begin
			a = axis_gap(s.x, last_x) + axis_gap(s.y, last_y) + axis_gap(s.z, last_z);
			r.act = act_t'(a);
			if (a > act_thr) begin
				if (lead_cnt >= LEADS) begin
					burst_on = 1'b1;
				end else begin
					lead_vals[lead_cnt] = a;
					lead_cnt++;
				end
				if (burst_on) begin
					burst_sum += a;
					if (burst_sum > SUM_MAX) burst_sum = SUM_MAX;
				end
			end else begin
				lead_cnt = 0;
				r.ev = EV_QUIET;
				if (burst_on) begin
					for (i = 0; i < LEADS; i++) begin
						burst_sum += lead_vals[i];
						if (burst_sum > SUM_MAX) burst_sum = SUM_MAX;
					end
					if (burst_sum > click_thr) r.ev = EV_CLICK;
				end
				burst_on = 1'b0;
				burst_sum = 0;
			end
		end
		last_x = s.x;
		last_y = s.y;
		last_z = s.z;
		return r;
	endfunction

	// next sample whose activity against the last one sent is about amount
	function automatic sample_t make_step(int amount);
		sample_t s;
		int      pos [3];
		bit      up [3];
		int      rem;
		int      room;
		int      d;
		int      a;
		int      pass;
		rem = amount;
		pos = gen_pos;
		for (a = 0; a < 3; a++) begin
			if (32767 - pos[a] >= rem && pos[a] + 32768 >= rem)
				up[a] = 1'($urandom_range(1));
			else
				up[a] = (32767 - pos[a]) >= (pos[a] + 32768);
		end
		for (pass = 0; pass < 2; pass++) begin
			for (a = 0; a < 3; a++) begin
				room = up[a] ? 32767 - pos[a] : pos[a] + 32768;
				d = (pass == 0 && a < 2) ? $urandom_range(0, room) : room;
				if (d > rem) d = rem;
				pos[a] += up[a] ? d : -d;
				rem -= d;
			end
		end
		s.x = axis_t'(pos[0]);
		s.y = axis_t'(pos[1]);
		s.z = axis_t'(pos[2]);
		return s;
	endfunction

	function automatic int move_amt();
		int a;
		a = int'(act_thr) + 1;
		a += ($urandom_range(1) == 0) ? $urandom_range(0, 64) : $urandom_range(0, ACT_MAX);
		return (a > ACT_MAX) ? ACT_MAX : a;
	endfunction

	function automatic int quiet_amt();
		int top;
		top = (act_thr > ACT_MAX) ? ACT_MAX : act_thr;
		if ($urandom_range(1) == 0 && top > 16) top = 16;
		return $urandom_range(0, top);
	endfunction

	function automatic axis_t rand_axis();
		case ($urandom_range(3))
			0: return AX_MIN;
			1: return AX_MAX;
			default: return axis_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_sample(sample_t s, detect_t want);
		while ($urandom_range(99) < src_idle) begin
			accel_ch.valid <= 1'b0;
			@(negedge clk);
		end
		accel_ch.valid <= 1'b1;
		accel_ch.accel_x <= s.x;
		accel_ch.accel_y <= s.y;
		accel_ch.accel_z <= s.z;
		@(posedge clk);
		while (!accel_ch.ready) @(posedge clk);
		due_detects.push_back(want);
		gen_pos = '{int'(s.x), int'(s.y), int'(s.z)};
		@(negedge clk);
	endtask

	task automatic drain();
		accel_ch.valid <= 1'b0;
		while (due_detects.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(logic idx, logic [DATA_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_ACT_THR)
			act_thr = 32'(val[ACT_W-1:0]);
		else
			click_thr = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_phase(int n_items);
		sample_t s;
		int      sent;
		int      k;
		int      len;
		sent = 0;
		while (sent < n_items) begin
			k = $urandom_range(99);
			if (k < 75) begin
				// movement run of random length closed by a quiet sample
				len = $urandom_range(0, 12);
				repeat (len) begin
					s = make_step(move_amt());
					send_sample(s, predict_detect(s));
				end
				s = make_step(quiet_amt());
				send_sample(s, predict_detect(s));
				sent += len + 1;
			end else begin
				if (k < 90) begin
					s.x = rand_axis();
					s.y = rand_axis();
					s.z = rand_axis();
				end else begin
					s = make_step(int'(act_thr) + $urandom_range(0, 1));
				end
				send_sample(s, predict_detect(s));
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		detect_t want;
		if (arst_n && event_ch.valid && event_ch.ready) begin
			if (due_detects.size() == 0) begin
				errors++;
				$display("%0t: unexpected detect ev=%0d act=%0d", $time,
					event_ch.event_res, event_ch.activity);
			end else begin
				want = due_detects.pop_front();
				if (event_ch.event_res !== want.ev) begin
					errors++;
					$display("%0t: event_res expected %0d, got %0d", $time,
						want.ev, event_ch.event_res);
				end
				if (event_ch.activity !== want.act) begin
					errors++;
					$display("%0t: activity expected %0d, got %0d", $time,
						want.act, event_ch.activity);
				end
			end
		end
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				event_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				event_ch.ready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	initial begin
		sample_t s;
		detect_t d;
		int      i;
		int      phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		accel_ch.valid = 1'b0;
		accel_ch.accel_x = '0;
		accel_ch.accel_y = '0;
		accel_ch.accel_z = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_vecs[i]) begin
			s.x = axis_t'(dir_vecs[i].x);
			s.y = axis_t'(dir_vecs[i].y);
			s.z = axis_t'(dir_vecs[i].z);
			d = predict_detect(s);
			if (dir_vecs[i].typed) d = '{dir_vecs[i].ev, act_t'(dir_vecs[i].act)};
			send_sample(s, d);
		end
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					reg_write(REG_ACT_THR, 0);
					reg_write(REG_CLICK_THR, 0);
				end
				1: begin
					reg_write(REG_ACT_THR, ACT_MAX);
					reg_write(REG_CLICK_THR, 32'hFFFF_FFFF);
				end
				2: begin
					reg_write(REG_ACT_THR, $urandom_range(0, 5000));
					reg_write(REG_CLICK_THR, $urandom_range(0, 300000));
					hold_req = 1'b1;
				end
				3: begin
					reg_write(REG_ACT_THR, $urandom_range(0, 100000));
					reg_write(REG_CLICK_THR, $urandom);
				end
				4: begin
					reg_write(REG_ACT_THR, DATA_W'(ACT_THR_RST));
					reg_write(REG_CLICK_THR, CLICK_THR_RST);
					src_idle = 0;
					sink_idle = 0;
				end
				default: begin
					reg_write(REG_ACT_THR, $urandom_range(100, 3000));
					reg_write(REG_CLICK_THR, $urandom_range(10000, 100000));
				end
			endcase
			if (phase == 3) begin
				// sender waits mid-phase for the pipe to empty
				run_phase(50);
				drain();
				run_phase(50);
			end else begin
				run_phase(100);
			end
			drain();
			src_idle = 36;
			sink_idle = 36;
		end

		// one long full-swing burst under a click threshold one below the largest
		reg_write(REG_ACT_THR, DATA_W'(ACT_THR_RST));
		reg_write(REG_CLICK_THR, 32'hFFFF_FFFE);
		s = make_step(0);
		send_sample(s, predict_detect(s));
		for (i = 0; i < LONG_RUN; i++) begin
			s.x = i[0] ? AX_MIN : AX_MAX;
			s.y = s.x;
			s.z = s.x;
			send_sample(s, predict_detect(s));
		end
		s = make_step(0);
		send_sample(s, predict_detect(s));
		drain();
		repeat (6) @(negedge clk);

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
src/abcd_pkg.sv
src/abcd_accel_if.sv
src/abcd_event_if.sv
src/accel_burst_click_detector.sv
tb/tb.sv
